FILE: design/bmc_pkg.sv
// Shared types and constants for the bank mapper with cycle IRQ.
package bmc_pkg;

  // Item commands.
  typedef enum logic [1:0] {
    CMD_SELECT = 2'd0,
    CMD_PARAM  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_t;

  // Kind of the program area that a CPU address falls in.
  typedef enum logic [1:0] {
    KIND_ROM      = 2'd0,
    KIND_RAM      = 2'd1,
    KIND_OPEN_BUS = 2'd2,
    KIND_UNMAPPED = 2'd3
  } prg_kind_t;

  // Nametable mirroring modes.
  typedef enum logic [1:0] {
    MIR_A10  = 2'd0,
    MIR_A11  = 2'd1,
    MIR_ZERO = 2'd2,
    MIR_ONE  = 2'd3
  } mirror_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PRG_AND = 2'd0;
  localparam logic [1:0] CFG_PRG_OR  = 2'd1;
  localparam logic [1:0] CFG_CHR_AND = 2'd2;
  localparam logic [1:0] CFG_CHR_OR  = 2'd3;

  // Parameter register numbers above the character banks.
  localparam logic [3:0] REG_PRG0   = 4'd8;
  localparam logic [3:0] REG_PRG1   = 4'd9;
  localparam logic [3:0] REG_PRG2   = 4'd10;
  localparam logic [3:0] REG_PRG3   = 4'd11;
  localparam logic [3:0] REG_MIRROR = 4'd12;
  localparam logic [3:0] REG_IRQ_EN = 4'd13;
  localparam logic [3:0] REG_CNT_LO = 4'd14;
  localparam logic [3:0] REG_CNT_HI = 4'd15;

  localparam logic [7:0] PRG_LOW_MASK  = 8'h3F;
  localparam logic [7:0] PRG_FIXED_TOP = 8'hFF;

  // Bank and mask state seen by the translation stage.
  typedef struct packed {
    logic [7:0][7:0] char_banks;
    logic [3:0][7:0] prog_banks;
    logic [1:0]      mirror_mode;
    logic            irq_pending;
    logic [7:0]      prg_and;
    logic [7:0]      prg_or;
    logic [7:0]      chr_and;
    logic [7:0]      chr_or;
  } map_state_t;

endpackage

FILE: design/bmc_req_if.sv
// Input word channel: command, write byte and the addresses to translate.
interface bmc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  write_value;
  logic [15:0] cpu_address;
  logic [13:0] ppu_address;

  modport source (output valid, command, write_value, cpu_address, ppu_address,
                  input ready);
  modport sink   (input valid, command, write_value, cpu_address, ppu_address,
                  output ready);
endinterface

FILE: design/bmc_rsp_if.sv
// Result word channel: translated banks, nametable page and IRQ line.
interface bmc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] prg_kind;
  logic [7:0] prg_bank;
  logic [7:0] chr_bank;
  logic       nametable_page;
  logic       irq_line;

  modport source (output valid, prg_kind, prg_bank, chr_bank, nametable_page, irq_line,
                  input ready);
  modport sink   (input valid, prg_kind, prg_bank, chr_bank, nametable_page, irq_line,
                  output ready);
endinterface

FILE: design/bmc_cfg_if.sv
// Configuration write channel: register index and data byte.
interface bmc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/bank_mapper_with_cycle_irq.sv
// Top level of the bank mapper with CPU-cycle IRQ counter.
// Each accepted word (command select, parameter write, cycle tick or plain lookup)
// updates the mapper state at the edge where it is accepted. Its addresses are held in
// the address stage and translated against the state that includes it into the result
// register, which holds the result word on the result port until the result side takes it.
// One word is accepted every cycle; the address stage and the result register run as
// a two-entry pipeline, so a full throughput of one word per clock is kept while
// the result side takes every word, and input stalls only when both stages hold
// words the result side has not taken. Configuration writes are taken at any time
// and change the AND/OR bank masks; they are meant to happen while idle.
module bank_mapper_with_cycle_irq (
  input logic     clk,
  input logic     rst,
  bmc_req_if.sink req,
  bmc_rsp_if.source rsp,
  bmc_cfg_if.sink cfg
);

  bmc_pkg::map_state_t state;
  logic                accept;
  logic                stage_ready;

  assign req.ready = stage_ready;
  assign accept    = req.valid && stage_ready;

  // State registers and configuration masks.
  bmc_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (req.command),
    .write_value (req.write_value),
    .cfg         (cfg),
    .state       (state)
  );

  // Address translation pipeline.
  bmc_xlate u_xlate (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_ready    (stage_ready),
    .cpu_address (req.cpu_address),
    .ppu_address (req.ppu_address),
    .state       (state),
    .rsp         (rsp)
  );

endmodule

FILE: design/bmc_regs.sv
// Mapper state: bank registers, mirroring, IRQ counter and configuration masks.
module bmc_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          command,
  input  logic [7:0]          write_value,
  bmc_cfg_if.sink             cfg,
  output bmc_pkg::map_state_t state
);

  logic [3:0]      selected_register;
  logic [7:0][7:0] char_banks;
  logic [3:0][7:0] prog_banks;
  logic [1:0]      mirror_mode;
  logic [1:0]      irq_enables;
  logic [15:0]     irq_count;
  logic            irq_pending;
  logic [7:0]      prg_and, prg_or, chr_and, chr_or;
  logic [15:0]     count_dec;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_and <= 8'hFF;
      prg_or  <= 8'h00;
      chr_and <= 8'hFF;
      chr_or  <= 8'h00;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bmc_pkg::CFG_PRG_AND: prg_and <= cfg.data;
        bmc_pkg::CFG_PRG_OR:  prg_or  <= cfg.data;
        bmc_pkg::CFG_CHR_AND: chr_and <= cfg.data;
        bmc_pkg::CFG_CHR_OR:  chr_or  <= cfg.data;
        default: ;
      endcase
    end
  end

  assign count_dec = irq_count - 16'd1;

  // Apply one accepted word to the mapper state.
  always_ff @(posedge clk) begin
    if (rst) begin
      selected_register <= 4'd0;
      for (int i = 0; i < 8; i++) begin
        char_banks[i] <= 8'(i);
      end
      prog_banks[0] <= 8'h00;
      prog_banks[1] <= 8'h00;
      prog_banks[2] <= 8'h01;
      prog_banks[3] <= 8'hFE;
      mirror_mode <= 2'd0;
      irq_enables <= 2'd0;
      irq_count   <= 16'd0;
      irq_pending <= 1'b0;
    end else if (accept) begin
      unique case (bmc_pkg::cmd_t'(command))
        bmc_pkg::CMD_SELECT: selected_register <= write_value[3:0];
        bmc_pkg::CMD_PARAM: begin
          if (!selected_register[3]) begin
            char_banks[selected_register[2:0]] <= write_value;
          end else begin
            unique case (selected_register)
              bmc_pkg::REG_PRG0:   prog_banks[0] <= write_value;
              bmc_pkg::REG_PRG1:   prog_banks[1] <= write_value & bmc_pkg::PRG_LOW_MASK;
              bmc_pkg::REG_PRG2:   prog_banks[2] <= write_value & bmc_pkg::PRG_LOW_MASK;
              bmc_pkg::REG_PRG3:   prog_banks[3] <= write_value & bmc_pkg::PRG_LOW_MASK;
              bmc_pkg::REG_MIRROR: mirror_mode <= write_value[1:0];
              bmc_pkg::REG_IRQ_EN: begin
                irq_enables <= {write_value[7], write_value[0]};
                irq_pending <= 1'b0;
              end
              bmc_pkg::REG_CNT_LO: irq_count[7:0]  <= write_value;
              bmc_pkg::REG_CNT_HI: irq_count[15:8] <= write_value;
              default: ;
            endcase
          end
        end
        bmc_pkg::CMD_TICK: begin
          // Count down while enabled; reaching zero raises the IRQ if allowed.
          if (irq_enables[1]) begin
            irq_count <= count_dec;
            if (count_dec == 16'd0 && irq_enables[0]) begin
              irq_pending <= 1'b1;
            end
          end
        end
        bmc_pkg::CMD_LOOKUP: ;
      endcase
    end
  end

  assign state.char_banks  = char_banks;
  assign state.prog_banks  = prog_banks;
  assign state.mirror_mode = mirror_mode;
  assign state.irq_pending = irq_pending;
  assign state.prg_and     = prg_and;
  assign state.prg_or      = prg_or;
  assign state.chr_and     = chr_and;
  assign state.chr_or      = chr_or;

endmodule

FILE: design/bmc_xlate.sv
// Address stage and result register: translates addresses against the updated state.
module bmc_xlate (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  output logic                in_ready,
  input  logic [15:0]         cpu_address,
  input  logic [13:0]         ppu_address,
  input  bmc_pkg::map_state_t state,
  bmc_rsp_if.source           rsp
);

  logic        s1_valid;
  logic [15:0] s1_cpu;
  logic [13:0] s1_ppu;
  logic        advance;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  out_prg, out_chr;
  logic        out_page, out_irq;

  logic [1:0]  kind_next;
  logic [7:0]  raw_bank, prg_next, chr_next;
  logic        page_next;

  // The stage moves forward whenever the result register is free or being emptied.
  assign advance  = s1_valid && (!out_valid || rsp.ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cpu <= cpu_address;
      s1_ppu <= ppu_address;
    end
  end

  // Program bank lookup by 8K window of the CPU address.
  always_comb begin
    kind_next = bmc_pkg::KIND_ROM;
    raw_bank  = 8'h00;
    prg_next  = 8'h00;
    unique case (s1_cpu[15:13])
      3'd0, 3'd1, 3'd2: kind_next = bmc_pkg::KIND_UNMAPPED;
      3'd3: begin
        if (state.prog_banks[0][6]) begin
          kind_next = state.prog_banks[0][7] ? bmc_pkg::KIND_RAM : bmc_pkg::KIND_OPEN_BUS;
        end else begin
          raw_bank = state.prog_banks[0] & bmc_pkg::PRG_LOW_MASK;
          prg_next = (raw_bank & state.prg_and) | state.prg_or;
        end
      end
      3'd4, 3'd5, 3'd6: begin
        raw_bank = state.prog_banks[2'(s1_cpu[14:13] + 2'd1)];
        prg_next = (raw_bank & state.prg_and) | state.prg_or;
      end
      3'd7: begin
        raw_bank = bmc_pkg::PRG_FIXED_TOP;
        prg_next = (raw_bank & state.prg_and) | state.prg_or;
      end
    endcase
  end

  // Character bank in the pattern area, nametable page above it.
  always_comb begin
    chr_next  = 8'h00;
    page_next = 1'b0;
    if (!s1_ppu[13]) begin
      chr_next = (state.char_banks[s1_ppu[12:10]] & state.chr_and) | state.chr_or;
    end else begin
      unique case (bmc_pkg::mirror_t'(state.mirror_mode))
        bmc_pkg::MIR_A10:  page_next = s1_ppu[10];
        bmc_pkg::MIR_A11:  page_next = s1_ppu[11];
        bmc_pkg::MIR_ZERO: page_next = 1'b0;
        bmc_pkg::MIR_ONE:  page_next = 1'b1;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind <= kind_next;
      out_prg  <= prg_next;
      out_chr  <= chr_next;
      out_page <= page_next;
      out_irq  <= state.irq_pending;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.prg_kind       = out_kind;
  assign rsp.prg_bank       = out_prg;
  assign rsp.chr_bank       = out_chr;
  assign rsp.nametable_page = out_page;
  assign rsp.irq_line       = out_irq;

endmodule

FILE: sim/mapper_checker.sv
// Checker for the bank mapper: predicts every result word and compares it with the DUT.
`timescale 1ns / 100ps

module mapper_checker
  import bmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  bmc_req_if        req,
  bmc_rsp_if        rsp,
  bmc_cfg_if        cfg,
  output int        errors,
  output int        pending,
  output int        checked,
  output int        irq_words
);

  // Address map boundaries.
  localparam logic [15:0] CPU_RAM_BASE = 16'h6000;
  localparam logic [15:0] CPU_ROM_BASE = 16'h8000;
  localparam logic [15:0] CPU_TOP_BASE = 16'hE000;
  localparam logic [13:0] PPU_NT_BASE  = 14'h2000;

  typedef struct packed {
    prg_kind_t  kind;
    logic [7:0] prg_bank;
    logic [7:0] chr_bank;
    logic       page;
    logic       irq;
  } map_result_t;

  // Shadow copy of the mapper state and the bank masks.
  logic [7:0]  chr_bank_q [8];
  logic [7:0]  prg_bank_q [4];
  logic [3:0]  sel_q;
  mirror_t     mirror_q;
  logic [1:0]  irq_en_q;
  logic [15:0] irq_count_q;
  logic        irq_flag_q;
  logic [7:0]  prg_and_q, prg_or_q, chr_and_q, chr_or_q;

  map_result_t expected_words [$];
  map_result_t want;

  function automatic logic [7:0] mask_prg(input logic [7:0] bank);
    return (bank & prg_and_q) | prg_or_q;
  endfunction

  // Applies one parameter byte to the currently selected register.
  function automatic void write_param(input logic [7:0] val);
    if (sel_q < REG_PRG0) begin
      chr_bank_q[sel_q[2:0]] = val;
    end else begin
      case (sel_q)
        REG_PRG0: prg_bank_q[0] = val;
        REG_PRG1, REG_PRG2, REG_PRG3: prg_bank_q[sel_q[1:0]] = val & PRG_LOW_MASK;
        REG_MIRROR: mirror_q = mirror_t'(val[1:0]);
        REG_IRQ_EN: begin
          irq_en_q   = {val[7], val[0]};
          irq_flag_q = 1'b0;
        end
        REG_CNT_LO: irq_count_q[7:0] = val;
        default: irq_count_q[15:8] = val;
      endcase
    end
  endfunction

  // Updates the state for one word and translates its addresses afterwards.
  function automatic map_result_t map_word(input cmd_t cmd, input logic [7:0] val,
                                           input logic [15:0] cpu, input logic [13:0] ppu);
    map_result_t r;
    r = '0;
    case (cmd)
      CMD_SELECT: sel_q = val[3:0];
      CMD_PARAM: write_param(val);
      CMD_TICK: begin
        if (irq_en_q[1]) begin
          irq_count_q = irq_count_q - 16'd1;
          if (irq_count_q == 16'd0 && irq_en_q[0]) irq_flag_q = 1'b1;
        end
      end
      default: ;
    endcase

    // Program side.
    if (cpu < CPU_RAM_BASE) begin
      r.kind = KIND_UNMAPPED;
    end else if (cpu < CPU_ROM_BASE) begin
      if (prg_bank_q[0][6]) begin
        r.kind = prg_bank_q[0][7] ? KIND_RAM : KIND_OPEN_BUS;
      end else begin
        r.kind     = KIND_ROM;
        r.prg_bank = mask_prg(prg_bank_q[0] & PRG_LOW_MASK);
      end
    end else if (cpu < CPU_TOP_BASE) begin
      r.kind     = KIND_ROM;
      r.prg_bank = mask_prg(prg_bank_q[2'(cpu[14:13] + 2'd1)]);
    end else begin
      r.kind     = KIND_ROM;
      r.prg_bank = mask_prg(PRG_FIXED_TOP);
    end

    // Character side: pattern banks below the nametables, mirroring above.
    if (ppu < PPU_NT_BASE) begin
      r.chr_bank = (chr_bank_q[ppu[12:10]] & chr_and_q) | chr_or_q;
    end else begin
      case (mirror_q)
        MIR_A10:  r.page = ppu[10];
        MIR_A11:  r.page = ppu[11];
        MIR_ZERO: r.page = 1'b0;
        default:  r.page = 1'b1;
      endcase
    end
    r.irq = irq_flag_q;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_val,
                                      input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
    end
  endfunction

  // Watch all three channels at every edge.
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) chr_bank_q[i] = 8'(i);
      prg_bank_q  = '{8'h00, 8'h00, 8'h01, 8'hFE};
      sel_q       = '0;
      mirror_q    = MIR_A10;
      irq_en_q    = '0;
      irq_count_q = '0;
      irq_flag_q  = 1'b0;
      prg_and_q   = 8'hFF;
      prg_or_q    = 8'h00;
      chr_and_q   = 8'hFF;
      chr_or_q    = 8'h00;
      errors      = 0;
      checked     = 0;
      irq_words   = 0;
      expected_words.delete();
    end else begin
      // Results are checked before new words are queued.
      if (rsp.valid && rsp.ready) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected, actual kind %0d bank %0h",
                   $time, rsp.prg_kind, rsp.prg_bank);
        end else begin
          want = expected_words.pop_front();
          check_field("prg_kind", 8'(want.kind), 8'(rsp.prg_kind));
          check_field("prg_bank", want.prg_bank, rsp.prg_bank);
          check_field("chr_bank", want.chr_bank, rsp.chr_bank);
          check_field("nametable_page", 8'(want.page), 8'(rsp.nametable_page));
          check_field("irq_line", 8'(want.irq), 8'(rsp.irq_line));
          checked++;
          if (want.irq) irq_words++;
        end
      end

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_PRG_AND: prg_and_q = cfg.data;
          CFG_PRG_OR:  prg_or_q  = cfg.data;
          CFG_CHR_AND: chr_and_q = cfg.data;
          default:     chr_or_q  = cfg.data;
        endcase
      end

      if (req.valid && req.ready) begin
        expected_words.push_back(map_word(cmd_t'(req.command), req.write_value,
                                          req.cpu_address, req.ppu_address));
      end
    end
    pending <= expected_words.size();
  end

endmodule

FILE: sim/tb.sv
// Testbench top for the bank mapper: stimulus, receiver stalls, mask phases and verdict.
`timescale 1ns / 100ps

module tb;
  import bmc_pkg::*;

  localparam int         PHASE_WORDS  = 300;
  localparam int         PHASES       = 6;
  localparam int         HOLD_PERIOD  = 1500;
  localparam int         HOLD_CYCLES  = 120;
  localparam logic [3:0] REG_CHR_LAST = 4'd7;
  localparam logic [7:0] IRQ_BOTH_ON  = 8'h81;
  localparam logic [7:0] IRQ_ALL_OFF  = 8'h00;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_SPARSE} sink_mode_t;

  logic clk = 1'b0;
  logic rst;

  bmc_req_if req_ch ();
  bmc_rsp_if rsp_ch ();
  bmc_cfg_if cfg_ch ();

  int errors, pending, checked, irq_words;
  int cmd_count [4];
  int words_sent;
  int mask_settings;
  int burst_left;
  bit gaps_on;

  always #4 clk = ~clk;

  bank_mapper_with_cycle_irq dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  mapper_checker chk (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg       (cfg_ch),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .irq_words (irq_words)
  );

  // Offers one word, waits for it to be taken, then maybe opens a gap.
  task automatic send_word(input cmd_t cmd, input logic [7:0] val,
                           input logic [15:0] cpu, input logic [13:0] ppu);
    req_ch.valid       <= 1'b1;
    req_ch.command     <= cmd;
    req_ch.write_value <= val;
    req_ch.cpu_address <= cpu;
    req_ch.ppu_address <= ppu;
    do @(posedge clk); while (!req_ch.ready);
    cmd_count[cmd]++;
    words_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stops sending and waits until every result word has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all four mask registers back to back while the block is idle.
  task automatic set_masks(input logic [7:0] pa, input logic [7:0] po,
                           input logic [7:0] ca, input logic [7:0] co);
    logic [1:0] idx  [4];
    logic [7:0] vals [4];
    idx  = '{CFG_PRG_AND, CFG_PRG_OR, CFG_CHR_AND, CFG_CHR_OR};
    vals = '{pa, po, ca, co};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    mask_settings++;
  endtask

  // Address extremes, every command and the corner cases of the map and the counter.
  task automatic send_directed();
    send_word(CMD_LOOKUP, 8'h00, 16'h0000, 14'h0000);
    send_word(CMD_LOOKUP, 8'hFF, 16'h5FFF, 14'h1FFF);
    send_word(CMD_LOOKUP, 8'h00, 16'h6000, 14'h2000);
    send_word(CMD_LOOKUP, 8'h00, 16'hFFFF, 14'h3FFF);
    // A tick with the counter disabled changes nothing.
    send_word(CMD_TICK, 8'h00, 16'hC000, 14'h0400);
    // Program bank 0: RAM, open bus, then ROM; upper select bits are ignored.
    send_word(CMD_SELECT, {4'hF, REG_PRG0}, 16'h8000, 14'h0800);
    send_word(CMD_PARAM, 8'hC0, 16'h7FFF, 14'h0C00);
    send_word(CMD_PARAM, 8'h40, 16'h6000, 14'h1000);
    send_word(CMD_PARAM, 8'h3F, 16'h6FFF, 14'h1400);
    send_word(CMD_SELECT, {4'h0, REG_PRG1}, 16'h9FFF, 14'h1800);
    send_word(CMD_PARAM, 8'hFF, 16'h8000, 14'h1C00);
    send_word(CMD_SELECT, {4'h0, REG_PRG3}, 16'hDFFF, 14'h03FF);
    send_word(CMD_PARAM, 8'h80, 16'hC000, 14'h2FFF);
    // All four mirroring modes.
    send_word(CMD_SELECT, {4'h0, REG_MIRROR}, 16'hE000, 14'h2400);
    send_word(CMD_PARAM, {6'h3F, MIR_ONE}, 16'hE000, 14'h2000);
    send_word(CMD_PARAM, {6'h00, MIR_ZERO}, 16'hA000, 14'h3C00);
    send_word(CMD_PARAM, {6'h3F, MIR_A11}, 16'hA000, 14'h2800);
    send_word(CMD_PARAM, {6'h00, MIR_A10}, 16'hB000, 14'h2400);
    send_word(CMD_SELECT, {4'h0, REG_CHR_LAST}, 16'h4000, 14'h1FFF);
    send_word(CMD_PARAM, 8'hFF, 16'h2000, 14'h1C00);
    // Counter reaches zero, wraps, and the pending IRQ holds until register 13.
    send_word(CMD_SELECT, {4'h0, REG_CNT_LO}, 16'h6000, 14'h0000);
    send_word(CMD_PARAM, 8'h02, 16'h6000, 14'h0000);
    send_word(CMD_SELECT, {4'h0, REG_IRQ_EN}, 16'h6000, 14'h0000);
    send_word(CMD_PARAM, IRQ_BOTH_ON, 16'h8000, 14'h2000);
    repeat (3) send_word(CMD_TICK, 8'hFF, 16'hFFFF, 14'h3FFF);
    send_word(CMD_PARAM, IRQ_ALL_OFF, 16'h8000, 14'h2000);
    send_word(CMD_TICK, 8'h00, 16'h8000, 14'h2000);
  endtask

  // One random sequence: mostly select/parameter pairs and tick runs.
  task automatic send_random();
    int         pick;
    logic [3:0] reg_no;
    logic [7:0] val;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      reg_no = 4'($urandom);
      val    = 8'($urandom);
      // Keep counter loads small so the IRQ fires often.
      if (reg_no == REG_CNT_LO && $urandom_range(0, 1) == 1) val = 8'($urandom_range(0, 15));
      if (reg_no == REG_CNT_HI && $urandom_range(0, 3) != 0) val = 8'h00;
      if (reg_no == REG_IRQ_EN && $urandom_range(0, 1) == 1) val = val | IRQ_BOTH_ON;
      send_word(CMD_SELECT, {4'($urandom), reg_no}, 16'($urandom), 14'($urandom));
      send_word(CMD_PARAM, val, 16'($urandom), 14'($urandom));
    end else if (pick < 70) begin
      repeat ($urandom_range(1, 24))
        send_word(CMD_TICK, 8'($urandom), 16'($urandom), 14'($urandom));
    end else if (pick < 82) begin
      send_word(CMD_LOOKUP, 8'($urandom), 16'($urandom), 14'($urandom));
    end else begin
      send_word(cmd_t'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), 14'($urandom));
    end
  endtask

  // Receiver: changing stall patterns plus a periodic long hold-off.
  initial begin
    sink_mode_t mode;
    int         mode_left;
    int         cycle_no;
    int         hold_left;
    mode      = SINK_OPEN;
    mode_left = 0;
    cycle_no  = 0;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (cycle_no % HOLD_PERIOD == 0) hold_left = HOLD_CYCLES;
      if (mode_left == 0) begin
        mode      = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 400);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:   rsp_ch.ready <= 1'b1;
          SINK_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
          SINK_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
          default:     rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Main stimulus and verdict.
  initial begin
    logic [7:0] pa, po, ca, co;
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.command     <= CMD_LOOKUP;
    req_ch.write_value <= '0;
    req_ch.cpu_address <= '0;
    req_ch.ppu_address <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_PRG_AND;
    cfg_ch.data        <= '0;
    gaps_on            = 1'b1;
    burst_left         = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words run against the reset masks.
    send_directed();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin pa = 8'hFF; po = 8'h00; ca = 8'hFF; co = 8'h00; end
        1: begin pa = 8'h00; po = 8'h00; ca = 8'h00; co = 8'h00; end
        2: begin pa = 8'h00; po = 8'hFF; ca = 8'h00; co = 8'hFF; end
        3: begin pa = 8'hFF; po = 8'hFF; ca = 8'hFF; co = 8'hFF; end
        default: begin
          pa = 8'($urandom); po = 8'($urandom); ca = 8'($urandom); co = 8'($urandom);
        end
      endcase
      set_masks(pa, po, ca, co);
      // One phase runs without sender gaps.
      gaps_on = (p != 2);
      for (int n = words_sent; words_sent < n + PHASE_WORDS; ) send_random();
    end

    drain();
    $display("tb: sent %0d words (%0d select, %0d param, %0d tick, %0d lookup), %0d mask sets",
             words_sent, cmd_count[CMD_SELECT], cmd_count[CMD_PARAM], cmd_count[CMD_TICK],
             cmd_count[CMD_LOOKUP], mask_settings);
    $display("tb: compared %0d result words, %0d with the IRQ line high", checked, irq_words);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
design/bmc_pkg.sv
design/bmc_req_if.sv
design/bmc_rsp_if.sv
design/bmc_cfg_if.sv
design/bmc_regs.sv
design/bmc_xlate.sv
design/bank_mapper_with_cycle_irq.sv
sim/mapper_checker.sv
sim/tb.sv
